/* sv/ntc_pkg.sv */
// Shared constants, types and the log2 table generator for the NTC beta converter.
// No dependencies; imported by every module of the block.
package ntc_pkg;

  localparam int unsigned LOG_TABLE_BITS_DEF = 6;
  localparam int unsigned LW     = 25;  // log2 value, unsigned Q20
  localparam int unsigned QBITS  = 18;  // quotient bits of the divider
  localparam int unsigned NUM_W  = 55;  // rounded dividend
  localparam int unsigned DEN_W  = 41;  // doubled divisor
  localparam int unsigned CFG_W  = 20;

  localparam logic [29:0] LN2_Q30  = 30'd744261118;
  localparam logic [22:0] NUM_K    = 23'd6553600;  // 100 * 2^16
  localparam logic [6:0]  CENTI    = 7'd100;
  localparam logic [15:0] ZERO_CK  = 16'd27315;
  localparam logic [17:0] TEMP_MAX = 18'd99900;
  localparam logic [3:0]  EDGE_MV  = 4'd10;

  localparam logic [2:0] REG_REF  = 3'd0;
  localparam logic [2:0] REG_PULL = 3'd1;
  localparam logic [2:0] REG_NOM  = 3'd2;
  localparam logic [2:0] REG_BETA = 3'd3;
  localparam logic [2:0] REG_T0   = 3'd4;

  typedef struct packed {
    logic fault;
    logic dz;
    logic neg;
    logic ovf;
  } ntc_side_t;

  // log2(1 + i/2^tb) in Q20 by repeated truncating squaring of a Q30 mantissa
  function automatic logic [20:0] log_entry(input int unsigned i, input int unsigned tb);
    logic [63:0] y;
    logic [20:0] r;
    r = '0;
    if (i >= (32'd1 << tb)) begin
      r = 21'h100000;
    end else begin
      y = (64'd1 << 30) + (64'(i) << (30 - tb));
      for (int k = 19; k >= 0; k--) begin
        y = (y * y) >> 30;
        if (y >= (64'd2 << 30)) begin
          r[k] = 1'b1;
          y = y >> 1;
        end
      end
    end
    return r;
  endfunction

endpackage

/* sv/ntc_thermistor_beta_to_temp.sv */
// NTC thermistor divider voltage to temperature by the beta equation, fully pipelined.
// Depends on ntc_pkg, ntc_log2 and ntc_div.
//
// Input channel: in_valid_i/in_ready_o with node_millivolts_i (signed mV at the
// divider node). Output channel: out_valid_o/out_ready_i with temp_centi_celsius_o
// (signed 0.01 degC, clamped to +-999.00) and sensor_fault_o (open or short,
// temperature then reads -999.00).
// Throughput: one request per cycle unless the output stalls. From the accepting edge
// to out_valid_o a request passes through 28 register stages: the 9 arithmetic stages
// (two log2 stages, the ln2 and product multipliers), the 18-stage quotient divider
// and the output register.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 ref mV, 1 pull-up ohms, 2 nominal ohms, 3 beta K, 4 nominal 0.01 degC);
// write only while the pipeline is empty.
// Reset clears all valid bits and restores the default register values.
// A stalled receiver freezes the whole pipeline in place; in_ready_o drops
// while the output holds an untaken result, nothing is lost or repeated.
module ntc_thermistor_beta_to_temp import ntc_pkg::*; #(
  parameter int unsigned LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [13:0] node_millivolts_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [17:0] temp_centi_celsius_o,
  output logic               sensor_fault_o
);

  localparam int unsigned PRE = 9;
  localparam int unsigned LAT = PRE + QBITS + 1;

  logic [12:0] ref_q;
  logic [19:0] pull_q, nom_q;
  logic [13:0] beta_q;
  logic [14:0] t0c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q  <= 13'd2500;
      pull_q <= 20'd10000;
      nom_q  <= 20'd10000;
      beta_q <= 14'd3950;
      t0c_q  <= 15'd2500;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_REF:  ref_q  <= cfg_data_i[12:0];
        REG_PULL: pull_q <= cfg_data_i;
        REG_NOM:  nom_q  <= cfg_data_i;
        REG_BETA: beta_q <= cfg_data_i[13:0];
        REG_T0:   t0c_q  <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  logic [19:0] rp, r0;
  logic [13:0] beta_g;
  logic [16:0] t0k_x;
  logic [15:0] t0k;

  assign rp     = (pull_q == '0) ? 20'd1 : pull_q;
  assign r0     = (nom_q == '0) ? 20'd1 : nom_q;
  assign beta_g = (beta_q == '0) ? 14'd1 : beta_q;
  assign t0k_x  = 17'($signed(t0c_q)) + 17'(ZERO_CK);
  assign t0k    = t0k_x[15:0];

  logic adv;
  logic [LAT-1:0] vld_q;

  assign adv        = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // stage 0: fault test and operand capture
  logic signed [14:0] vs, rv, edge_hi;
  logic [12:0] s0_v_q, s0_rv_q;
  logic [PRE-1:0] fault_q;

  assign vs      = 15'(node_millivolts_i);
  assign rv      = $signed({2'b0, ref_q}) - vs;
  assign edge_hi = $signed({2'b0, ref_q}) - $signed({11'b0, EDGE_MV});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_v_q  <= vs[12:0];
      s0_rv_q <= rv[12:0];
      fault_q <= {fault_q[PRE-2:0],
                  (vs <= $signed({11'b0, EDGE_MV})) || (vs >= edge_hi)};
    end
  end

  // stages 1-2: four log2 values
  logic [LW-1:0] l_rp, l_v, l_r0, l_rv;

  ntc_log2 #(.W(20), .TB(LOG_TABLE_BITS)) u_log_rp (
    .clk_i(clk_i), .en_i(adv), .x_i(rp), .l_o(l_rp));
  ntc_log2 #(.W(13), .TB(LOG_TABLE_BITS)) u_log_v (
    .clk_i(clk_i), .en_i(adv), .x_i(s0_v_q), .l_o(l_v));
  ntc_log2 #(.W(20), .TB(LOG_TABLE_BITS)) u_log_r0 (
    .clk_i(clk_i), .en_i(adv), .x_i(r0), .l_o(l_r0));
  ntc_log2 #(.W(13), .TB(LOG_TABLE_BITS)) u_log_rv (
    .clk_i(clk_i), .en_i(adv), .x_i(s0_rv_q), .l_o(l_rv));

  // stage 3: log2(R/R0) magnitude and sign
  logic signed [LW+1:0] d_d, d_abs;
  logic [25:0] s3_mag_q;
  logic s3_neg_q;

  assign d_d   = $signed({2'b0, l_rp}) + $signed({2'b0, l_v})
               - $signed({2'b0, l_r0}) - $signed({2'b0, l_rv});
  assign d_abs = d_d[LW+1] ? -d_d : d_d;

  // stage 4: times ln2
  logic [55:0] prod_d, s4_prod_q;
  logic s4_neg_q;
  assign prod_d = {30'b0, s3_mag_q} * {26'b0, LN2_Q30};

  // stage 5: round to Q16
  logic [56:0] rnd;
  logic [21:0] lqm;
  logic signed [22:0] s5_lq_q;
  logic [29:0] s5_tb_q;
  assign rnd = {1'b0, s4_prod_q} + (57'd1 << 33);
  assign lqm = rnd[55:34];

  // stage 6: products
  logic signed [39:0] s6_tl_q;
  logic [20:0] s6_bk_q;
  logic [52:0] s6_num_q;

  // stage 7: denominator
  logic signed [40:0] den_d, s7_den_q;
  logic [52:0] s7_num_q;
  assign den_d = $signed({4'b0, s6_bk_q, 16'b0}) + $signed({s6_tl_q[39], s6_tl_q});

  // stage 8: rounded dividend and divisor
  logic [39:0] ad;
  logic [NUM_W-1:0] n_d, s8_n_q;
  logic [DEN_W-1:0] dv_d, s8_d_q;
  ntc_side_t side_d, s8_side_q;
  assign ad          = s7_den_q[40] ? 40'(-s7_den_q) : s7_den_q[39:0];
  assign n_d         = {1'b0, s7_num_q, 1'b0} + {15'b0, ad};
  assign dv_d        = {ad, 1'b0};
  assign side_d.fault = fault_q[PRE-2];
  assign side_d.dz    = (s7_den_q == '0);
  assign side_d.neg   = s7_den_q[40];
  assign side_d.ovf   = {4'b0, n_d[NUM_W-1:QBITS]} >= dv_d;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_mag_q  <= d_abs[25:0];
      s3_neg_q  <= d_d[LW+1];
      s4_prod_q <= prod_d;
      s4_neg_q  <= s3_neg_q;
      s5_lq_q   <= s4_neg_q ? -$signed({1'b0, lqm}) : $signed({1'b0, lqm});
      s5_tb_q   <= {14'b0, t0k} * {16'b0, beta_g};
      s6_tl_q   <= $signed({1'b0, t0k}) * s5_lq_q;
      s6_bk_q   <= {7'b0, beta_g} * {14'b0, CENTI};
      s6_num_q  <= {23'b0, s5_tb_q} * {30'b0, NUM_K};
      s7_den_q  <= den_d;
      s7_num_q  <= s6_num_q;
      s8_n_q    <= n_d;
      s8_d_q    <= dv_d;
      s8_side_q <= side_d;
    end
  end

  logic [QBITS-1:0] q;
  ntc_side_t        side_q;

  ntc_div u_div (
    .clk_i(clk_i), .en_i(adv), .n_i(s8_n_q), .d_i(s8_d_q),
    .side_i(s8_side_q), .q_o(q), .side_o(side_q));

  // output stage: kelvin to Celsius, clamp
  logic signed [19:0] qs, kel, cel;
  logic signed [17:0] temp_d, temp_q;
  logic fault_oq;

  assign qs  = $signed({2'b0, q});
  assign kel = side_q.neg ? -qs : qs;
  assign cel = kel - $signed({4'b0, ZERO_CK});

  always_comb begin
    if (side_q.fault) begin
      temp_d = -$signed(TEMP_MAX);
    end else if (side_q.dz) begin
      temp_d = $signed(TEMP_MAX);
    end else if (side_q.ovf) begin
      temp_d = side_q.neg ? -$signed(TEMP_MAX) : $signed(TEMP_MAX);
    end else if (cel > $signed({2'b0, TEMP_MAX})) begin
      temp_d = $signed(TEMP_MAX);
    end else if (cel < -$signed({2'b0, TEMP_MAX})) begin
      temp_d = -$signed(TEMP_MAX);
    end else begin
      temp_d = cel[17:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      temp_q   <= temp_d;
      fault_oq <= side_q.fault;
    end
  end

  assign out_valid_o          = vld_q[LAT-1];
  assign temp_centi_celsius_o = temp_q;
  assign sensor_fault_o       = fault_oq;

  a_fault_val : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sensor_fault_o |-> temp_centi_celsius_o == -$signed(TEMP_MAX))
    else $error("fault result not at minimum");

  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (temp_centi_celsius_o <= $signed(TEMP_MAX))
                 && (temp_centi_celsius_o >= -$signed(TEMP_MAX)))
    else $error("result out of range");

  a_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("request taken during output stall");

endmodule

/* sv/ntc_log2.sv */
// Two-stage log2 unit: leading-one normalise with table lookup, then interpolation.
// Depends on ntc_pkg.
module ntc_log2 import ntc_pkg::*; #(
  parameter int unsigned W  = 20,
  parameter int unsigned TB = LOG_TABLE_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [W-1:0]  x_i,
  output logic [LW-1:0] l_o
);

  localparam int unsigned TAB_N = 1 << TB;
  localparam int unsigned RB    = 30 - TB;
  localparam int unsigned EW    = $clog2(W);

  logic [20:0] tab [TAB_N+1];

  for (genvar g = 0; g <= TAB_N; g++) begin : g_tab
    localparam logic [20:0] ENT = log_entry(g, TB);
    assign tab[g] = ENT;
  end

  logic [EW-1:0] e_d, e_q;
  logic [W-1:0]  norm;
  logic [29:0]   f30;
  logic [TB-1:0] idx;
  logic [20:0]   lo, hi, lo_q, dif_q;
  logic [RB-1:0] rem_q;
  logic          dn_q;
  logic [20+RB:0] prod;
  logic [20:0]   sh, part;
  logic [LW-1:0] l_d, l_q;

  always_comb begin
    e_d = '0;
    for (int i = 0; i < W; i++) begin
      if (x_i[i]) e_d = EW'(i);
    end
  end

  assign norm = x_i << (EW'(W - 1) - e_d);
  assign f30  = {norm[W-2:0], {(31 - W){1'b0}}};
  assign idx  = f30[29 -: TB];
  assign lo   = tab[idx];
  assign hi   = tab[{1'b0, idx} + 1'b1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q   <= e_d;
      lo_q  <= lo;
      dn_q  <= hi < lo;
      dif_q <= (hi < lo) ? lo - hi : hi - lo;
      rem_q <= f30[RB-1:0];
    end
  end

  assign prod = {{RB{1'b0}}, dif_q} * {21'b0, rem_q};
  assign sh   = prod[RB +: 21];
  assign part = dn_q ? lo_q - sh : lo_q + sh;
  assign l_d  = (LW'(e_q) << 20) + LW'(part);

  always_ff @(posedge clk_i) begin
    if (en_i) l_q <= l_d;
  end

  assign l_o = l_q;

endmodule

/* sv/ntc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, side flags carried along.
// Depends on ntc_pkg.
module ntc_div import ntc_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] n_i,
  input  logic [DEN_W-1:0] d_i,
  input  ntc_side_t        side_i,
  output logic [QBITS-1:0] q_o,
  output ntc_side_t        side_o
);

  localparam int unsigned TW = DEN_W + QBITS;

  logic [NUM_W-1:0] rem_q [QBITS];
  logic [DEN_W-1:0] d_q   [QBITS];
  logic [QBITS-1:0] qv_q  [QBITS];
  ntc_side_t        sd_q  [QBITS];

  for (genvar g = 0; g < QBITS; g++) begin : g_step
    localparam int unsigned K = QBITS - 1 - g;
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] d_in;
    logic [QBITS-1:0] qv_in;
    ntc_side_t        sd_in;
    logic [TW-1:0]    trial, remx;
    logic             ge;

    if (g == 0) begin : g_first
      assign rem_in = n_i;
      assign d_in   = d_i;
      assign qv_in  = '0;
      assign sd_in  = side_i;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign d_in   = d_q[g-1];
      assign qv_in  = qv_q[g-1];
      assign sd_in  = sd_q[g-1];
    end

    assign trial = TW'(d_in) << K;
    assign remx  = TW'(rem_in);
    assign ge    = remx >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= ge ? NUM_W'(remx - trial) : rem_in;
        d_q[g]   <= d_in;
        qv_q[g]  <= qv_in | (QBITS'(ge) << K);
        sd_q[g]  <= sd_in;
      end
    end
  end

  assign q_o    = qv_q[QBITS-1];
  assign side_o = sd_q[QBITS-1];

endmodule
